@@ rtl/ntc_pkg.sv @@
// shared widths, constants and types of the thermistor temperature pipeline
package ntc_pkg;

  // converter and field widths
  localparam int ADC_BITS = 12;
  localparam int CODE_W   = 12;
  localparam int BETA_W   = 14;
  localparam int COMP_W   = 7;
  localparam int T_W      = 17;
  localparam int CFG_W    = 14;
  localparam int IDX_W    = 1;

  // register indexes of the configuration port
  localparam logic [IDX_W-1:0] REG_BETA = 1'd0;
  localparam logic [IDX_W-1:0] REG_COMP = 1'd1;

  localparam logic [BETA_W-1:0] BETA_RST = 14'd3950;
  localparam logic [COMP_W-1:0] COMP_RST = 7'd5;

  // divider terms: num = 330*code, den = 329*2^ADC_BITS - num
  localparam int NUM_MUL = 330;
  localparam int DEN_MUL = 329;
  localparam int NUM_W   = ADC_BITS + 9;
  localparam logic [NUM_W-1:0] DEN_FULL = NUM_W'(DEN_MUL) << ADC_BITS;

  // log2 in Q.16 with a Q1.30 mantissa
  localparam int M_W     = 31;
  localparam int FRAC_W  = 16;
  localparam int P_W     = $clog2(NUM_W);
  localparam int LOG_W   = P_W + FRAC_W;
  localparam int L_W     = LOG_W + 1;
  localparam int LOG_LAT = 1 + FRAC_W;

  // 298.15*ln2 in Q.16
  localparam int K_W = 24;
  localparam logic [K_W-1:0] K_Q16 = 24'd13543790;
  localparam int KL_W = K_W + 1 + L_W;

  // beta denominator and quotient
  localparam int D_W     = ((BETA_W + 32 > KL_W) ? BETA_W + 32 : KL_W) + 1;
  localparam int DEN_W   = D_W - 1;
  localparam int NB_W    = 15 + BETA_W;
  localparam int N_W     = NB_W + 32 + 1;
  localparam int Q_W     = 17;
  localparam int R_W     = (N_W > DEN_W + Q_W) ? N_W : DEN_W + Q_W;
  localparam int DIV_LAT = 1 + Q_W;
  localparam int T25_C   = 29815;

  // output math
  localparam int TV_W   = Q_W + 4;
  localparam int KELVIN = 27315;
  localparam int T_MIN  = -11000;
  localparam int T_MAX  = 54000;

  // flags that ride along with each request
  typedef struct packed {
    logic inv;
    logic bzero;
    logic dneg;
  } flags_t;

endpackage

@@ rtl/ntc_log2.sv @@
// pipelined log2 in Q.16: normalize stage then one squaring stage per fraction bit
module ntc_log2 (
  input  logic                          clk,
  input  logic                          en,
  input  logic [ntc_pkg::NUM_W-1:0]     x,
  output logic [ntc_pkg::LOG_W-1:0]     log
);

  logic [ntc_pkg::P_W-1:0]    p_s [0:ntc_pkg::FRAC_W];
  logic [ntc_pkg::M_W-1:0]    m_s [0:ntc_pkg::FRAC_W];
  logic [ntc_pkg::FRAC_W-1:0] f_s [0:ntc_pkg::FRAC_W];

  logic [ntc_pkg::P_W-1:0]              p_next;
  logic [ntc_pkg::NUM_W+ntc_pkg::M_W-2:0] wide;
  logic [ntc_pkg::NUM_W+ntc_pkg::M_W-2:0] shifted;

  // msb position and mantissa alignment
  always_comb begin
    p_next = '0;
    for (int i = 0; i < ntc_pkg::NUM_W; i++) begin
      if (x[i]) p_next = ntc_pkg::P_W'(i);
    end
    wide    = {x, {(ntc_pkg::M_W-1){1'b0}}};
    shifted = wide >> p_next;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_s[0] <= p_next;
      m_s[0] <= shifted[ntc_pkg::M_W-1:0];
      f_s[0] <= '0;
    end
  end

  // one fraction bit per squaring stage
  for (genvar g = 0; g < ntc_pkg::FRAC_W; g++) begin : g_sq
    logic [2*ntc_pkg::M_W-1:0] sq;
    logic [ntc_pkg::M_W:0]     s;
    assign sq = m_s[g] * m_s[g];
    assign s  = sq[2*ntc_pkg::M_W-1:ntc_pkg::M_W-1];
    always_ff @(posedge clk) begin
      if (en) begin
        p_s[g+1] <= p_s[g];
        m_s[g+1] <= s[ntc_pkg::M_W] ? s[ntc_pkg::M_W:1] : s[ntc_pkg::M_W-1:0];
        f_s[g+1] <= {f_s[g][ntc_pkg::FRAC_W-2:0], s[ntc_pkg::M_W]};
      end
    end
  end

  assign log = {p_s[ntc_pkg::FRAC_W], f_s[ntc_pkg::FRAC_W]};

endmodule

@@ rtl/ntc_div.sv @@
// pipelined restoring divider with rounding input, one quotient bit per stage
module ntc_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [ntc_pkg::N_W-1:0]     num,
  input  logic [ntc_pkg::DEN_W-1:0]   den,
  output logic [ntc_pkg::Q_W-1:0]     q,
  output logic                        sat
);

  logic [ntc_pkg::R_W-1:0]   rem [0:ntc_pkg::Q_W];
  logic [ntc_pkg::DEN_W-1:0] dd  [0:ntc_pkg::Q_W];
  logic [ntc_pkg::Q_W-1:0]   qq  [0:ntc_pkg::Q_W];
  logic                      st  [0:ntc_pkg::Q_W];

  // load stage and quotient overflow check
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= ntc_pkg::R_W'(num);
      dd[0]  <= den;
      qq[0]  <= '0;
      st[0]  <= ntc_pkg::R_W'(num) >= (ntc_pkg::R_W'(den) << ntc_pkg::Q_W);
    end
  end

  // compare and subtract, msb first
  for (genvar g = 0; g < ntc_pkg::Q_W; g++) begin : g_bit
    logic [ntc_pkg::R_W-1:0] trial;
    logic                    take;
    assign trial = ntc_pkg::R_W'(dd[g]) << (ntc_pkg::Q_W - 1 - g);
    assign take  = rem[g] >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[g+1] <= take ? rem[g] - trial : rem[g];
        dd[g+1]  <= dd[g];
        qq[g+1]  <= {qq[g][ntc_pkg::Q_W-2:0], take};
        st[g+1]  <= st[g];
      end
    end
  end

  assign q   = qq[ntc_pkg::Q_W];
  assign sat = st[ntc_pkg::Q_W];

endmodule

@@ rtl/ntc_beta_temperature.sv @@
// top level: thermistor code to temperature in hundredths of a degree C
//
// Input channel in_valid/in_ready carries one 12-bit converter code per
// request; output channel out_valid/out_ready carries temperature_centi and
// invalid. Two configuration registers (beta, compensation in tenths) are
// written through cfg_we/cfg_index/cfg_data and take effect at once.
// Throughput is one request per cycle while the output is not stalled. A
// request is loaded into the input stage at the accepting edge, then passes
// 17 log2 stages (normalize plus one squaring per fraction bit), four
// stages for the log difference, the beta multiply and the rounding
// numerator, 18 divider stages (an overflow check, then one quotient bit
// each) and the output register.
// The whole pipeline advances together; when the output holds a result that
// the receiver does not take, every stage holds and in_ready is low, so no
// request is lost or repeated.
// Reset clears all valid bits and loads beta 3950 and compensation +0.5 C.
// Codes of zero and codes at or above 3.29 V report invalid with zero.
module ntc_beta_temperature (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ntc_pkg::CODE_W-1:0]      adc_code,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [ntc_pkg::T_W-1:0]  temperature_centi,
  output logic                            invalid,
  input  logic                            cfg_we,
  input  logic [ntc_pkg::IDX_W-1:0]       cfg_index,
  input  logic [ntc_pkg::CFG_W-1:0]       cfg_data
);

  logic                         adv;
  logic [ntc_pkg::BETA_W-1:0]   beta;
  logic [ntc_pkg::COMP_W-1:0]   comp;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      beta <= ntc_pkg::BETA_RST;
      comp <= ntc_pkg::COMP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ntc_pkg::REG_BETA: beta <= cfg_data[ntc_pkg::BETA_W-1:0];
        ntc_pkg::REG_COMP: comp <= cfg_data[ntc_pkg::COMP_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // input stage: divider terms
  logic [ntc_pkg::ADC_BITS-1:0] code;
  logic [ntc_pkg::NUM_W-1:0]    num_c;
  logic                         v1;
  ntc_pkg::flags_t              f1;
  logic [ntc_pkg::NUM_W-1:0]    num1, den1;

  assign code  = ntc_pkg::ADC_BITS'(adc_code);
  assign num_c = ntc_pkg::NUM_W'(code) * ntc_pkg::NUM_W'(ntc_pkg::NUM_MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num1     <= num_c;
      den1     <= ntc_pkg::DEN_FULL - num_c;
      f1.inv   <= (code == '0) || (num_c >= ntc_pkg::DEN_FULL);
      f1.bzero <= 1'b0;
      f1.dneg  <= 1'b0;
    end
  end

  // log2 lanes for numerator and denominator
  logic [ntc_pkg::LOG_W-1:0] lnum, lden;

  ntc_log2 u_log_num (.clk(clk), .en(adv), .x(num1), .log(lnum));
  ntc_log2 u_log_den (.clk(clk), .en(adv), .x(den1), .log(lden));

  logic            lg_v [0:ntc_pkg::LOG_LAT-1];
  ntc_pkg::flags_t lg_f [0:ntc_pkg::LOG_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ntc_pkg::LOG_LAT; i++) lg_v[i] <= 1'b0;
    end else if (adv) begin
      lg_v[0] <= v1;
      for (int i = 1; i < ntc_pkg::LOG_LAT; i++) lg_v[i] <= lg_v[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lg_f[0] <= f1;
      for (int i = 1; i < ntc_pkg::LOG_LAT; i++) lg_f[i] <= lg_f[i-1];
    end
  end

  // log ratio, beta term, rounding numerator
  logic                              v2, v3, v4, v5;
  ntc_pkg::flags_t                   f2, f3, f4, f5;
  logic signed [ntc_pkg::L_W-1:0]    l2;
  logic signed [ntc_pkg::KL_W-1:0]   kl3;
  logic signed [ntc_pkg::D_W-1:0]    d4;
  logic [ntc_pkg::NB_W-1:0]          nb4;
  logic [ntc_pkg::N_W-1:0]           n5;
  logic [ntc_pkg::DEN_W-1:0]         dd5;
  logic signed [ntc_pkg::K_W:0]      kq;
  logic signed [ntc_pkg::D_W-1:0]    beta_sh;

  assign kq      = signed'({1'b0, ntc_pkg::K_Q16});
  assign beta_sh = signed'(ntc_pkg::D_W'({beta, 32'b0}));

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v2 <= lg_v[ntc_pkg::LOG_LAT-1];
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f2  <= lg_f[ntc_pkg::LOG_LAT-1];
      l2  <= signed'({1'b0, lnum}) - signed'({1'b0, lden});
      f3  <= f2;
      kl3 <= l2 * kq;
      f4  <= f3;
      d4  <= beta_sh + ntc_pkg::D_W'(kl3);
      nb4 <= ntc_pkg::NB_W'(beta) * ntc_pkg::NB_W'(ntc_pkg::T25_C);
      f5.inv   <= f4.inv;
      f5.bzero <= (beta == '0);
      f5.dneg  <= (d4 <= 0);
      n5  <= ntc_pkg::N_W'({nb4, 32'b0}) + ntc_pkg::N_W'(d4[ntc_pkg::D_W-2:1]);
      dd5 <= d4[ntc_pkg::DEN_W-1:0];
    end
  end

  // rounded quotient in hundredths of a kelvin
  logic [ntc_pkg::Q_W-1:0] q;
  logic                    sat;

  ntc_div u_div (.clk(clk), .en(adv), .num(n5), .den(dd5), .q(q), .sat(sat));

  logic            dv_v [0:ntc_pkg::DIV_LAT-1];
  ntc_pkg::flags_t dv_f [0:ntc_pkg::DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ntc_pkg::DIV_LAT; i++) dv_v[i] <= 1'b0;
    end else if (adv) begin
      dv_v[0] <= v5;
      for (int i = 1; i < ntc_pkg::DIV_LAT; i++) dv_v[i] <= dv_v[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_f[0] <= f5;
      for (int i = 1; i < ntc_pkg::DIV_LAT; i++) dv_f[i] <= dv_f[i-1];
    end
  end

  // celsius, compensation and clamp
  ntc_pkg::flags_t                  fo;
  logic [ntc_pkg::Q_W-1:0]          q_eff;
  logic signed [ntc_pkg::TV_W-1:0]  tv;
  logic signed [ntc_pkg::T_W-1:0]   t_next;

  assign fo    = dv_f[ntc_pkg::DIV_LAT-1];
  assign q_eff = fo.bzero ? '0 : q;
  assign tv    = signed'(ntc_pkg::TV_W'(q_eff))
               - ntc_pkg::TV_W'(ntc_pkg::KELVIN)
               + ntc_pkg::TV_W'(signed'(comp)) * ntc_pkg::TV_W'(10);

  always_comb begin
    priority if (fo.inv) begin
      t_next = '0;
    end else if (!fo.bzero && (fo.dneg || sat)) begin
      t_next = ntc_pkg::T_W'(ntc_pkg::T_MAX);
    end else if (tv < ntc_pkg::TV_W'(ntc_pkg::T_MIN)) begin
      t_next = ntc_pkg::T_W'(ntc_pkg::T_MIN);
    end else if (tv > ntc_pkg::TV_W'(ntc_pkg::T_MAX)) begin
      t_next = ntc_pkg::T_W'(ntc_pkg::T_MAX);
    end else begin
      t_next = tv[ntc_pkg::T_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_v[ntc_pkg::DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      temperature_centi <= t_next;
      invalid           <= fo.inv;
    end
  end

endmodule

@@ rtl/ntc_checker.sv @@
// port checker for the thermistor temperature block, bound to the top level
module ntc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic signed [ntc_pkg::T_W-1:0]  temperature_centi,
  input logic                            invalid
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(temperature_centi) && $stable(invalid))
    else $error("result changed while stalled");

  // no new request while the result waits
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken during stall");

  // invalid results carry zero
  a_inv: assert property (@(posedge clk) disable iff (rst)
    out_valid && invalid |-> temperature_centi == '0)
    else $error("invalid result not zero");

  // valid results stay within the clamp limits
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !invalid |->
      temperature_centi >= ntc_pkg::T_W'(ntc_pkg::T_MIN) &&
      temperature_centi <= ntc_pkg::T_W'(ntc_pkg::T_MAX))
    else $error("temperature out of range");

endmodule

bind ntc_beta_temperature ntc_checker u_ntc_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .temperature_centi(temperature_centi),
  .invalid(invalid)
);

@@ bench/testbench.sv @@
// testbench for the thermistor code to temperature pipeline
module testbench;

  // conversion constants of the temperature math
  localparam longint LN2_T25_Q16 = 64'd13543790;
  localparam longint T25_CENTI   = 29815;
  localparam longint ZERO_C      = 27315;
  localparam longint LOW_LIMIT   = -11000;
  localparam longint HIGH_LIMIT  = 54000;
  localparam longint QUOT_CAP    = 64'd1000000000000;
  localparam int     IDLE_LIMIT  = 3000;
  localparam int     DRAIN_LIMIT = 20000;
  localparam int     PIPE_DELAY  = 45;

  typedef struct {
    logic signed [ntc_pkg::T_W-1:0] centi;
    logic                           inv;
  } reading_t;

  typedef struct {
    bit                          is_write;
    logic [ntc_pkg::IDX_W-1:0]   idx;
    int                          data;
    int                          code;
    bit                          known;
    int                          centi;
    bit                          inv;
  } step_t;

  logic                            clk, rst;
  logic                            in_valid, in_ready, out_valid, out_ready, invalid;
  logic [ntc_pkg::CODE_W-1:0]      adc_code;
  logic signed [ntc_pkg::T_W-1:0]  temperature_centi;
  logic                            cfg_we;
  logic [ntc_pkg::IDX_W-1:0]       cfg_index;
  logic [ntc_pkg::CFG_W-1:0]       cfg_data;

  // local copy of the registers
  logic [ntc_pkg::BETA_W-1:0]        beta_reg;
  logic signed [ntc_pkg::COMP_W-1:0] comp_reg;

  reading_t pending_readings[$];
  int       errors;
  int       readings_seen;
  int       burst_left;
  bit       long_hold_done;

  ntc_beta_temperature dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .adc_code(adc_code),
    .out_valid(out_valid), .out_ready(out_ready),
    .temperature_centi(temperature_centi), .invalid(invalid),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // log2 in Q.16: msb position plus 16 bits from repeated squaring
  function automatic longint log2_fixed(longint unsigned x);
    int p;
    int i;
    longint unsigned m;
    longint frac;
    p = 0;
    frac = 0;
    while (p < 63 && (x >> (p + 1)) != 0) p++;
    if (p <= 30) m = x << (30 - p);
    else m = x >> (p - 30);
    for (i = 15; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac = frac | (64'sd1 << i);
      end
    end
    return (longint'(p) << 16) + frac;
  endfunction

  // temperature reading for one code under the current registers
  function automatic reading_t beta_temperature(logic [ntc_pkg::CODE_W-1:0] code_in);
    reading_t r;
    longint code, num, den, comp, beta, l, d, tck, t;
    longint unsigned n, ud, q;
    code = longint'(code_in & ((1 << ntc_pkg::ADC_BITS) - 1));
    num = 330 * code;
    den = (longint'(329) << ntc_pkg::ADC_BITS) - num;
    comp = longint'(comp_reg);
    beta = longint'(beta_reg);
    if (code == 0 || den <= 0) begin
      r.centi = '0;
      r.inv = 1'b1;
      return r;
    end
    l = log2_fixed(num) - log2_fixed(den);
    d = (beta << 32) + LN2_T25_Q16 * l;
    if (beta == 0) tck = 0;
    else if (d <= 0) tck = -1;
    else begin
      n = longint'(T25_CENTI * beta) << 32;
      ud = d;
      q = (n + ud / 2) / ud;
      if (q > QUOT_CAP) q = QUOT_CAP;
      tck = q;
    end
    if (tck < 0) t = HIGH_LIMIT;
    else begin
      t = tck - ZERO_C + 10 * comp;
      if (t < LOW_LIMIT) t = LOW_LIMIT;
      if (t > HIGH_LIMIT) t = HIGH_LIMIT;
    end
    r.centi = t[ntc_pkg::T_W-1:0];
    r.inv = 1'b0;
    return r;
  endfunction

  // register write once the pipeline has drained
  task automatic write_reg(logic [ntc_pkg::IDX_W-1:0] idx, int data);
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (PIPE_DELAY) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data[ntc_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ntc_pkg::REG_BETA) beta_reg = data[ntc_pkg::BETA_W-1:0];
    else if (idx == ntc_pkg::REG_COMP) comp_reg = data[ntc_pkg::COMP_W-1:0];
  endtask

  // offer one code in bursts with random gaps, record the expected reading
  task automatic send_code(int code, bit known, int centi, bit inv);
    reading_t r;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid <= 1'b1;
    adc_code <= code[ntc_pkg::CODE_W-1:0];
    do @(posedge clk); while (!in_ready);
    if (known) begin
      r.centi = centi[ntc_pkg::T_W-1:0];
      r.inv = inv;
    end else
      r = beta_temperature(code[ntc_pkg::CODE_W-1:0]);
    pending_readings.push_back(r);
  endtask

  // output check against the oldest expected reading
  always @(posedge clk) begin
    reading_t e;
    if (!rst && out_valid && out_ready) begin
      readings_seen++;
      if (pending_readings.size() == 0) begin
        errors++;
        $display("%0t: reading with none expected: centi %0d invalid %0d",
                 $time, temperature_centi, invalid);
      end else begin
        e = pending_readings.pop_front();
        if (e.centi !== temperature_centi || e.inv !== invalid) begin
          errors++;
          $display("%0t: expected centi %0d invalid %0d, got centi %0d invalid %0d",
                   $time, e.centi, e.inv, temperature_centi, invalid);
        end
      end
    end
  end

  // receiver: always ready, random, sparse, and one long hold
  initial begin
    int mode;
    int cyc;
    cyc = 0;
    mode = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 64 == 0) mode = $urandom_range(0, 2);
      if (!long_hold_done && readings_seen >= 300) begin
        out_ready <= 1'b0;
        repeat (250) @(posedge clk);
        long_hold_done = 1'b1;
      end else begin
        case (mode)
          0: begin
            out_ready <= 1'b1;
          end
          1: begin
            out_ready <= $urandom_range(0, 1);
          end
          default: begin
            out_ready <= (cyc % 4 == 0);
          end
        endcase
      end
    end
  end

  // watchdog on cycles with no request moving
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // directed steps: known values where obvious, predictor elsewhere
  step_t directed[] = '{
    '{0, ntc_pkg::REG_BETA, 0, 0,    1, 0,      1},
    '{0, ntc_pkg::REG_BETA, 0, 4084, 1, 0,      1},
    '{0, ntc_pkg::REG_BETA, 0, 4095, 1, 0,      1},
    '{0, ntc_pkg::REG_BETA, 0, 1,    0, 0,      0},
    '{0, ntc_pkg::REG_BETA, 0, 4083, 0, 0,      0},
    '{0, ntc_pkg::REG_BETA, 0, 2048, 0, 0,      0},
    '{0, ntc_pkg::REG_BETA, 0, 2730, 0, 0,      0},
    '{0, ntc_pkg::REG_BETA, 0, 1365, 0, 0,      0},
    '{0, ntc_pkg::REG_BETA, 0, 100,  0, 0,      0},
    '{1, ntc_pkg::REG_BETA, 0, 0,    0, 0,      0},
    '{0, ntc_pkg::REG_BETA, 0, 2000, 1, -11000, 0},
    '{0, ntc_pkg::REG_BETA, 0, 1,    1, -11000, 0},
    '{1, ntc_pkg::REG_BETA, 16383, 0, 0, 0,     0},
    '{1, ntc_pkg::REG_COMP, 64, 0,   0, 0,      0},
    '{0, ntc_pkg::REG_BETA, 0, 1,    0, 0,      0},
    '{0, ntc_pkg::REG_BETA, 0, 2048, 0, 0,      0},
    '{0, ntc_pkg::REG_BETA, 0, 4083, 0, 0,      0},
    '{1, ntc_pkg::REG_BETA, 1000, 0, 0, 0,      0},
    '{1, ntc_pkg::REG_COMP, 63, 0,   0, 0,      0},
    '{0, ntc_pkg::REG_BETA, 0, 1,    1, 54000,  0},
    '{0, ntc_pkg::REG_BETA, 0, 4080, 0, 0,      0},
    '{0, ntc_pkg::REG_BETA, 0, 3000, 0, 0,      0},
    '{0, ntc_pkg::REG_BETA, 0, 4084, 1, 0,      1}
  };

  initial begin
    int phase, k, code, sel, beta_pick, comp_pick;
    int wait_cycles;
    errors = 0;
    readings_seen = 0;
    burst_left = 0;
    long_hold_done = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    adc_code = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    beta_reg = ntc_pkg::BETA_RST;
    comp_reg = ntc_pkg::COMP_RST;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].is_write) write_reg(directed[i].idx, directed[i].data);
      else send_code(directed[i].code, directed[i].known, directed[i].centi,
                     directed[i].inv);
    end

    // random phases, each under its own register setting
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: beta_pick = 3950;
        1: beta_pick = 10000;
        2: beta_pick = $urandom_range(1000, 1500);
        3: beta_pick = $urandom_range(0, 16383);
        default: beta_pick = $urandom_range(1000, 10000);
      endcase
      case (phase)
        0: comp_pick = -50;
        1: comp_pick = 50;
        2: comp_pick = -64;
        default: comp_pick = $urandom_range(0, 127);
      endcase
      write_reg(ntc_pkg::REG_BETA, beta_pick);
      write_reg(ntc_pkg::REG_COMP, comp_pick & 8'h7f);
      for (k = 0; k < 185; k++) begin
        sel = $urandom_range(0, 9);
        if (sel < 7) code = $urandom_range(1, 4083);
        else if (sel == 7) code = $urandom_range(0, 4095);
        else if (sel == 8) code = $urandom_range(4076, 4095);
        else code = $urandom_range(0, 8);
        send_code(code, 1'b0, 0, 1'b0);
      end
    end
    in_valid <= 1'b0;

    // drain, then a final settling stretch
    wait_cycles = 0;
    while (pending_readings.size() != 0) begin
      @(posedge clk);
      wait_cycles++;
      if (wait_cycles >= DRAIN_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
    repeat (PIPE_DELAY) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
